// File: hdl/mise_pkg.sv
// Shared types and constants of the mesh index stream encoder.
`default_nettype none

package mise_pkg;

  // Fixed field widths of the beats on the ports.
  localparam int IDX_W  = 24;
  localparam int CODE_W = 25;
  localparam int STEP_W = 4;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CODING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UTF_SAFE    = 2'd2;

  // Coding modes.
  localparam logic MODE_DELTA      = 1'b0;
  localparam logic MODE_HIGH_WATER = 1'b1;

  // Surrogate-range escape constants.
  localparam logic [CODE_W-1:0] ESC_MARK   = 25'd55295;
  localparam logic [CODE_W-1:0] ESC_HIGH   = 25'd57343;
  localparam logic [CODE_W-1:0] ESC_SHIFT  = 25'd14000;
  localparam logic [CODE_W-1:0] WIDE_LIMIT = 25'd65535;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             first_of_mesh;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic              last_of_item;
    logic              wide_code;
    logic              index_error;
  } out_beat_t;

  typedef struct packed {
    logic              coding_mode;
    logic [STEP_W-1:0] mark_step;
    logic              utf_safe;
  } cfg_t;

  // Everything one index produces: one or two beats.
  typedef struct packed {
    out_beat_t first_beat;
    out_beat_t second_beat;
    logic      two_beats;
  } enc_t;

endpackage

`default_nettype wire

// File: hdl/mesh_index_stream_encoder.sv
// Top level of the mesh index stream encoder: registers, handshakes, config.
//
//   Channel  Direction  Handshake            Beat contents
//   in       into block in_valid / in_stall  vertex_index, first_of_mesh
//   out      out of blk out_valid / out_stall code_value, last_of_item,
//                                             wide_code, index_error
//   cfg      into block cfg_valid / cfg_ready cfg_index, cfg_data
//
// An index waits in the input register while the encoder computes its code
// words, and its first beat is loaded from there into the output register.
// Plain indices stream at one per cycle while the output does not stall and
// no second beat is pending. An escaped index produces two beats and holds
// the encoder until its second beat, kept in a pending register, goes out.
// Reset is synchronous, clears valids and tracking state and sets the configuration to its defaults.
// A stall on the output backs up through the input register to in_stall.
`default_nettype none

module mesh_index_stream_encoder
  import mise_pkg::*;
#(
  parameter int INDEX_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  cfg_t cfg;

  // Tracking state carried from index to index.
  logic [INDEX_BITS-1:0] prev;
  logic [INDEX_BITS:0]   high_water;
  logic [INDEX_BITS-1:0] prev_next;
  logic [INDEX_BITS:0]   high_water_next;

  // Input register, output register and the pending second beat.
  in_beat_t  in_q;
  logic      in_vld;
  out_beat_t out_q;
  logic      out_vld;
  out_beat_t pend_q;
  logic      pend_vld;

  enc_t enc;
  logic out_free;
  logic advance;

  mise_code #(
    .INDEX_BITS(INDEX_BITS)
  ) u_code (
    .item            (in_q),
    .cfg             (cfg),
    .prev            (prev),
    .high_water      (high_water),
    .enc             (enc),
    .prev_next       (prev_next),
    .high_water_next (high_water_next)
  );

  // The output slot can take a new beat when it is empty or being emptied.
  // The held index moves on only once any pending second beat has gone out.
  assign out_free = !out_vld || !out_stall;
  assign advance  = in_vld && !pend_vld && out_free;

  assign in_stall  = in_vld && !advance;
  assign out_valid = out_vld;
  assign out_data  = out_q;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coding_mode <= MODE_HIGH_WATER;
      cfg.mark_step   <= STEP_W'(1);
      cfg.utf_safe    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CODING_MODE: cfg.coding_mode <= cfg_data[0];
        REG_MARK_STEP:   cfg.mark_step   <= cfg_data[STEP_W-1:0];
        REG_UTF_SAFE:    cfg.utf_safe    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Tracking state updates once per index, when it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev       <= '0;
      high_water <= '0;
    end else if (advance) begin
      prev       <= prev_next;
      high_water <= high_water_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Output register and pending beat. A pending second beat always goes out
  // before the next index is allowed to load the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else if (pend_vld && out_free) begin
      out_vld  <= 1'b1;
      pend_vld <= 1'b0;
    end else if (advance) begin
      out_vld  <= 1'b1;
      pend_vld <= enc.two_beats;
    end else if (out_vld && !out_stall) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_vld && out_free) begin
      out_q <= pend_q;
    end else if (advance) begin
      out_q  <= enc.first_beat;
      pend_q <= enc.second_beat;
    end
  end

  // A pending beat only exists behind a beat in the output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> out_vld)
    else $error("pending beat without an output beat");

  // An escape marker is always followed by its second beat.
  a_marker_has_tail: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_q.last_of_item) |-> pend_vld)
    else $error("escape marker without a second beat");

  // The second beat of an escape is shown right after the marker leaves.
  a_tail_follows: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_stall && pend_vld) |=> (out_vld && out_q.last_of_item))
    else $error("second escape beat did not follow the marker");

  // The encoder never loads a new index over a pending beat.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    advance |-> !pend_vld)
    else $error("index advanced over a pending beat");

  // An index error is a single final beat.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.index_error) |-> (out_q.last_of_item && !pend_vld))
    else $error("index error beat is not a single final beat");

endmodule

`default_nettype wire

// File: hdl/mise_code.sv
// Combinational encoder for one index: code words and next state.
`default_nettype none

module mise_code
  import mise_pkg::*;
#(
  parameter int INDEX_BITS = 24
) (
  input  wire in_beat_t              item,
  input  wire cfg_t                  cfg,
  input  wire logic [INDEX_BITS-1:0] prev,
  input  wire logic [INDEX_BITS:0]   high_water,
  output enc_t                       enc,
  output logic [INDEX_BITS-1:0]      prev_next,
  output logic [INDEX_BITS:0]        high_water_next
);

  localparam int VW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int HW = INDEX_BITS + 1;
  localparam int EW = (HW > CODE_W) ? HW : CODE_W;

  logic [VW-1:0]          v;
  logic [HW-1:0]          vh;
  logic [STEP_W-1:0]      step;
  logic [INDEX_BITS-1:0]  prev_eff;
  logic [HW-1:0]          hw_eff;
  logic signed [HW-1:0]   d;
  logic [HW-1:0]          z;
  logic [EW-1:0]          ze;
  logic signed [EW-1:0]   de;
  logic signed [EW-1:0]   adj;
  logic [EW-1:0]          zadj;
  logic                   esc_delta;
  logic                   err;
  logic [HW-1:0]          s;
  logic [EW-1:0]          se;
  logic                   esc_hw;
  logic [HW-1:0]          raised;

  assign v    = item.vertex_index[VW-1:0];
  assign vh   = HW'(v);
  assign step = (cfg.mark_step == '0) ? STEP_W'(1) : cfg.mark_step;

  // A new mesh restarts both trackers before this index is coded.
  assign prev_eff = item.first_of_mesh ? '0 : prev;
  assign hw_eff   = item.first_of_mesh ? (HW'(step) - HW'(1)) : high_water;

  // Delta path: zigzag of the signed difference.
  assign d  = $signed(vh) - $signed({1'b0, prev_eff});
  assign z  = HW'(d <<< 1) ^ {HW{d[HW-1]}};
  assign ze = EW'(z);
  assign de = EW'(d);
  assign adj  = d[HW-1] ? (de + $signed(EW'(ESC_SHIFT))) : (de - $signed(EW'(ESC_SHIFT)));
  assign zadj = EW'(adj <<< 1) ^ {EW{adj[EW-1]}};
  assign esc_delta = (ze >= EW'(ESC_MARK)) && (ze <= EW'(ESC_HIGH));

  // High-water path.
  assign err    = vh > hw_eff;
  assign s      = hw_eff - vh;
  assign se     = EW'(s);
  assign esc_hw = cfg.utf_safe && (se >= EW'(ESC_MARK)) && (se <= EW'(ESC_HIGH));

  always_comb begin
    enc.first_beat  = '{code_value: ESC_MARK, last_of_item: 1'b0,
                        wide_code: 1'b0, index_error: 1'b0};
    enc.second_beat = '{code_value: '0, last_of_item: 1'b1,
                        wide_code: 1'b0, index_error: 1'b0};
    enc.two_beats   = 1'b0;
    if (cfg.coding_mode == MODE_DELTA) begin
      if (esc_delta) begin
        enc.second_beat.code_value = zadj[CODE_W-1:0];
        enc.two_beats = 1'b1;
      end else begin
        enc.first_beat.code_value   = ze[CODE_W-1:0];
        enc.first_beat.last_of_item = 1'b1;
        enc.first_beat.wide_code    = ze > EW'(WIDE_LIMIT);
      end
    end else begin
      if (err) begin
        enc.first_beat.code_value   = '0;
        enc.first_beat.last_of_item = 1'b1;
        enc.first_beat.index_error  = 1'b1;
      end else if (esc_hw) begin
        enc.second_beat.code_value = se[CODE_W-1:0] - ESC_SHIFT;
        enc.two_beats = 1'b1;
      end else begin
        enc.first_beat.code_value   = se[CODE_W-1:0];
        enc.first_beat.last_of_item = 1'b1;
        enc.first_beat.wide_code    = cfg.utf_safe && (se > EW'(WIDE_LIMIT));
      end
    end
  end

  // Both trackers advance on every index in either mode.
  assign raised          = vh + HW'(step);
  assign prev_next       = INDEX_BITS'(v);
  assign high_water_next = (raised > hw_eff) ? raised : hw_eff;

endmodule

`default_nettype wire
